// ----- sv/assert_macros.svh -----
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, checked every clock outside reset
`define ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ----- sv/srp_pkg.sv -----
//------------------------------------------------------------------------------
// srp_pkg
// types, codes and defaults for the srp ceiling manager
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package srp_pkg;
   localparam int NumTasksDefault   = 32;
   localparam int NumMutexesDefault = 16;
   localparam int LevelBitsDefault  = 8;

   typedef enum logic [2:0] {
      MODE_SET_LEVEL = 3'd0,
      MODE_USE       = 3'd1,
      MODE_LOCK      = 3'd2,
      MODE_UNLOCK    = 3'd3,
      MODE_DETACH    = 3'd4,
      MODE_CREATE    = 3'd5,
      MODE_DESTROY   = 3'd6,
      MODE_BAD       = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_DEADLOCK = 3'd2,
      ST_NOTOWNER = 3'd3,
      ST_BUSY     = 3'd4,
      ST_REJECTED = 3'd5,
      ST_KILLED   = 3'd6
   } status_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [4:0] task_req;
      logic [3:0] mutex;
      logic [7:0] level;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] sys_ceil;
      logic [4:0] stack_depth;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_WALK,
      S_SCAN,
      S_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request
      logic exec;      // do the part of the request that needs no walk
      logic walk_init; // start a mutex walk
      logic visit;     // current mutex of the walk is being looked at
      logic walk_step; // process one mutex of the walk
      logic scan_step; // process one task of a recompute scan
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_walk;  // exec requested a mutex walk
      logic walk_last;  // current mutex is the last
      logic scan_need;  // current mutex needs a task scan
      logic scan_last;  // current task is the last
   } stat_type;
endpackage

// ----- sv/srp_ctrl.sv -----
//------------------------------------------------------------------------------
// srp_ctrl
// sequencer for request capture, walks over mutexes and task scans
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module srp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srp_pkg::cmd_type  cmd,
   input  srp_pkg::stat_type stat
);
   import srp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.need_walk) begin
               cmd.walk_init = 1'b1;
               state_in = S_WALK;
            end else begin
               state_in = S_OUT;
            end
         end
         S_WALK: begin
            cmd.visit = 1'b1;
            if (stat.scan_need) begin
               state_in = S_SCAN;
            end else begin
               cmd.walk_step = 1'b1;
               if (stat.walk_last) state_in = S_OUT;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               cmd.walk_step = 1'b1;
               state_in = stat.walk_last ? S_OUT : S_WALK;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ----- sv/srp_dp.sv -----
//------------------------------------------------------------------------------
// srp_dp
// task and mutex state, ceiling stack and recompute datapath
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module srp_dp #(
   parameter int NUM_TASKS   = srp_pkg::NumTasksDefault,
   parameter int NUM_MUTEXES = srp_pkg::NumMutexesDefault,
   parameter int LEVEL_BITS  = srp_pkg::LevelBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  srp_pkg::req_type  req_data,
   output srp_pkg::rsp_type  rsp_data,
   input  srp_pkg::cmd_type  cmd,
   output srp_pkg::stat_type stat
);
   import srp_pkg::*;

   localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
   localparam int DW = $clog2(NUM_MUTEXES + 1);

   req_type               req_ff;
   logic [LEVEL_BITS-1:0] lvl_ff   [NUM_TASKS];
   logic [4:0]            cnt_ff   [NUM_TASKS];
   logic [NUM_TASKS-1:0]  use_ff   [NUM_MUTEXES];
   logic [LEVEL_BITS-1:0] ceil_ff  [NUM_MUTEXES];
   logic                  own_v_ff [NUM_MUTEXES];
   logic [TW-1:0]         own_ff   [NUM_MUTEXES];
   logic [NUM_MUTEXES-1:0] ex_ff, pend_ff;
   logic [MW-1:0]         stm_ff   [NUM_MUTEXES];
   logic [LEVEL_BITS-1:0] stc_ff   [NUM_MUTEXES];
   logic [DW-1:0]         dep_ff;
   logic [2:0]            st_ff;
   logic                  walk_det_ff; // walk is a detach, else recompute
   logic [MW-1:0]         wi_ff;
   logic [TW-1:0]         ti_ff;
   logic [LEVEL_BITS-1:0] best_ff;

   logic                  t_ok, m_ok, m_live, own_is_t;
   logic [TW-1:0]         t;
   logic [MW-1:0]         m;
   logic [LEVEL_BITS-1:0] lv, top, mc, newc;
   logic                  det_hit, rc_hit;
   logic [LEVEL_BITS-1:0] cand;
   status_type            st_in;

   assign t      = req_ff.task_req[TW-1:0];
   assign m      = req_ff.mutex[MW-1:0];
   assign t_ok   = 32'(req_ff.task_req) < 32'(NUM_TASKS);
   assign m_ok   = 32'(req_ff.mutex) < 32'(NUM_MUTEXES);
   assign m_live = m_ok && ex_ff[m];
   assign own_is_t = own_v_ff[m] && own_ff[m] == t && t_ok;
   assign lv     = LEVEL_BITS'(req_ff.level);
   assign top    = (dep_ff == '0) ? '0 : stc_ff[MW'(dep_ff - 1'b1)];
   assign mc     = ceil_ff[m];
   assign newc   = (top > mc) ? top : mc;

   assign det_hit = ex_ff[wi_ff] && use_ff[wi_ff][t];
   assign rc_hit  = pend_ff[wi_ff];
   assign cand    = use_ff[wi_ff][ti_ff] ? lvl_ff[ti_ff] : '0;

   // status of the captured request against the current state
   always_comb begin
      st_in = ST_OK;
      if (req_ff.mode <= MODE_DETACH && !t_ok) begin
         st_in = ST_INVALID;
      end else begin
         unique case (req_ff.mode)
            MODE_SET_LEVEL: st_in = ST_OK;
            MODE_USE: begin
               if (!m_live) st_in = ST_INVALID;
               else if (use_ff[m][t]) st_in = ST_REJECTED;
            end
            MODE_LOCK: begin
               if (!m_live) st_in = ST_INVALID;
               else if (own_is_t) st_in = ST_DEADLOCK;
               else if (!use_ff[m][t] || lvl_ff[t] == '0 || own_v_ff[m] ||
                        32'(dep_ff) >= NUM_MUTEXES) st_in = ST_INVALID;
            end
            MODE_UNLOCK: begin
               if (!m_live) st_in = ST_INVALID;
               else if (!own_is_t) st_in = ST_NOTOWNER;
               else if (dep_ff == '0 || stm_ff[MW'(dep_ff - 1'b1)] != m)
                  st_in = ST_INVALID;
            end
            MODE_DETACH: begin
               if (lvl_ff[t] != '0 && cnt_ff[t] != '0) st_in = ST_KILLED;
            end
            MODE_CREATE: begin
               if (!m_ok) st_in = ST_INVALID;
               else if (ex_ff[m] && own_v_ff[m]) st_in = ST_BUSY;
            end
            MODE_DESTROY: begin
               if (!m_live) st_in = ST_INVALID;
               else if (own_v_ff[m]) st_in = ST_BUSY;
            end
            default: st_in = ST_INVALID;
         endcase
      end
   end

   always_comb begin
      stat = '0;
      stat.need_walk = (req_ff.mode == MODE_DETACH && t_ok && lvl_ff[t] != '0) ||
                       (req_ff.mode == MODE_UNLOCK && st_in == ST_OK &&
                        dep_ff == DW'(1));
      stat.walk_last = 32'(wi_ff) == NUM_MUTEXES - 1;
      stat.scan_need = walk_det_ff ? (det_hit && dep_ff == '0) : rc_hit;
      stat.scan_last = 32'(ti_ff) == NUM_TASKS - 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            lvl_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_MUTEXES; i++) begin
            use_ff[i]   <= '0;
            ceil_ff[i]  <= '0;
            own_v_ff[i] <= 1'b0;
         end
         ex_ff   <= '0;
         pend_ff <= '0;
         dep_ff  <= '0;
      end else begin
         if (cmd.load) req_ff <= req_data;
         if (cmd.exec) begin
            st_ff <= st_in;
            if (st_in == ST_OK) begin
               unique case (req_ff.mode)
                  MODE_SET_LEVEL: begin
                     if (lvl_ff[t] == '0) lvl_ff[t] <= lv;
                     cnt_ff[t] <= '0;
                  end
                  MODE_USE: begin
                     use_ff[m][t] <= 1'b1;
                     if (dep_ff != '0) pend_ff[m] <= 1'b1;
                     else if (mc < lvl_ff[t]) ceil_ff[m] <= lvl_ff[t];
                  end
                  MODE_LOCK: begin
                     if (cnt_ff[t] != 5'd31) cnt_ff[t] <= cnt_ff[t] + 5'd1;
                     own_v_ff[m] <= 1'b1;
                     own_ff[m]   <= t;
                     stm_ff[MW'(dep_ff)] <= m;
                     stc_ff[MW'(dep_ff)] <= newc;
                     dep_ff <= dep_ff + 1'b1;
                  end
                  MODE_UNLOCK: begin
                     if (cnt_ff[t] != '0) cnt_ff[t] <= cnt_ff[t] - 5'd1;
                     own_v_ff[m] <= 1'b0;
                     dep_ff <= dep_ff - 1'b1;
                  end
                  MODE_CREATE: begin
                     ex_ff[m]    <= 1'b1;
                     use_ff[m]   <= '0;
                     ceil_ff[m]  <= '0;
                     own_v_ff[m] <= 1'b0;
                     pend_ff[m]  <= 1'b0;
                  end
                  MODE_DESTROY: begin
                     ex_ff[m]   <= 1'b0;
                     pend_ff[m] <= 1'b0;
                     use_ff[m]  <= '0;
                     ceil_ff[m] <= '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         if (cmd.walk_init) begin
            walk_det_ff <= req_ff.mode == MODE_DETACH;
            wi_ff   <= '0;
            ti_ff   <= '0;
            best_ff <= '0;
         end
         // detach clears the bit first; at depth 0 a scan recomputes without it
         if (walk_det_ff && cmd.visit && det_hit) begin
            use_ff[wi_ff][t] <= 1'b0;
            if (dep_ff != '0) pend_ff[wi_ff] <= 1'b1;
         end
         if (cmd.scan_step) begin
            if (stat.scan_last) begin
               ceil_ff[wi_ff] <= (cand > best_ff) ? cand : best_ff;
               if (!walk_det_ff) pend_ff[wi_ff] <= 1'b0;
               ti_ff   <= '0;
               best_ff <= '0;
            end else begin
               ti_ff   <= ti_ff + 1'b1;
               if (cand > best_ff) best_ff <= cand;
            end
         end
         if (cmd.walk_step && !stat.walk_last) wi_ff <= wi_ff + 1'b1;
      end
   end

   assign rsp_data.status      = st_ff;
   assign rsp_data.sys_ceil    = 8'(top);
   assign rsp_data.stack_depth = 5'(dep_ff);
endmodule

// ----- sv/srp_ceiling_manager.sv -----
// most operations pass through the idle, exec and out states; a detach with a
// level set and the unlock that empties the stack walk every mutex, one per cycle
// unless scanning, plus one scan of every task for each ceiling recomputed; one
// operation in flight; the next request is taken in the cycle after the response;
// synchronous reset clears all task and mutex state and empties the stack
//------------------------------------------------------------------------------
// srp_ceiling_manager
// stack resource policy ceiling unit top level
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module srp_ceiling_manager #(
   parameter int NUM_TASKS   = srp_pkg::NumTasksDefault,
   parameter int NUM_MUTEXES = srp_pkg::NumMutexesDefault,
   parameter int LEVEL_BITS  = srp_pkg::LevelBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  srp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srp_pkg::rsp_type rsp_data
);
   import srp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   srp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .cmd, .stat
   );

   srp_dp #(
      .NUM_TASKS(NUM_TASKS), .NUM_MUTEXES(NUM_MUTEXES), .LEVEL_BITS(LEVEL_BITS)
   ) u_dp (
      .clock, .reset, .req_data, .rsp_data, .cmd, .stat
   );
endmodule

// ----- sv/srp_checker.sv -----
//------------------------------------------------------------------------------
// srp_checker
// port-level checks for the srp ceiling manager
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input srp_pkg::rsp_type rsp_data
);
   import srp_pkg::*;

   `ASSERT_IMP(a_excl, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `ASSERT_IMP(a_empty, clock, reset, rsp_valid && rsp_data.stack_depth == 5'd0,
      rsp_data.sys_ceil == 8'd0)
   `ASSERT_NXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind srp_ceiling_manager srp_checker u_srp_checker (.*);
